// File: hw/rtl/sxb_pkg.sv
// ----------------------------------------------------------------------------
// sxb_pkg
// shared types and constants for the shifted xor bitmap blit
// ----------------------------------------------------------------------------
package sxb_pkg;

    // field widths
    localparam int DATA_W     = 8;
    localparam int ADDR_OUT_W = 10;
    localparam int ORIGIN_X_W = 7;
    localparam int ORIGIN_Y_W = 5;
    localparam int WIDTH_W    = 8;
    localparam int HEIGHT_W   = 6;
    localparam int SHIFT_W    = 3;
    localparam int COL_W      = 4;
    localparam int ROW_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // geometry limits
    localparam int MAX_ROW_CELLS = 16;
    localparam int MAX_ROWS      = 32;
    localparam int ADDR_LIMIT    = 1023;

    // register reset values
    localparam int WIDTH_RESET  = 8;
    localparam int HEIGHT_RESET = 1;

    // parameter defaults
    localparam int unsigned ROW_BYTES_DEF  = 16;
    localparam int unsigned FRAME_ROWS_DEF = 32;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X    = 2'd0,
        REG_ORIGIN_Y    = 2'd1,
        REG_WIDTH_BITS  = 2'd2,
        REG_HEIGHT_ROWS = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [ORIGIN_X_W-1:0] origin_x;
        logic [ORIGIN_Y_W-1:0] origin_y;
        logic [WIDTH_W-1:0]    width_bits;
        logic [HEIGHT_W-1:0]   height_rows;
    } cfg_t;

    // position of one byte within the bitmap
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             bmp_end;
    } pos_t;

    // one frame buffer update
    typedef struct packed {
        logic [ADDR_OUT_W-1:0] frame_address;
        logic [DATA_W-1:0]     xor_mask;
        logic                  out_of_frame;
        logic                  last_of_item;
        logic                  last_of_bitmap;
    } upd_t;

endpackage

// File: hw/rtl/sxb_config.sv
// ----------------------------------------------------------------------------
// sxb_config
// configuration registers of the blit, written by index
// ----------------------------------------------------------------------------
module sxb_config (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [sxb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sxb_pkg::CFG_DATA_W-1:0] cfg_data,
    output sxb_pkg::cfg_t                  cfg
);
    import sxb_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ORIGIN_X:    cfg_next.origin_x    = cfg_data[ORIGIN_X_W-1:0];
                REG_ORIGIN_Y:    cfg_next.origin_y    = cfg_data[ORIGIN_Y_W-1:0];
                REG_WIDTH_BITS:  cfg_next.width_bits  = cfg_data[WIDTH_W-1:0];
                REG_HEIGHT_ROWS: cfg_next.height_rows = cfg_data[HEIGHT_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x    <= '0;
            cfg_reg.origin_y    <= '0;
            cfg_reg.width_bits  <= WIDTH_W'(WIDTH_RESET);
            cfg_reg.height_rows <= HEIGHT_W'(HEIGHT_RESET);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hw/rtl/sxb_position.sv
// ----------------------------------------------------------------------------
// sxb_position
// column and row counters that track where the next byte lands
// ----------------------------------------------------------------------------
module sxb_position (
    input  logic          clk,
    input  logic          rst_n,
    input  sxb_pkg::cfg_t cfg,
    input  logic          advance,
    output sxb_pkg::pos_t pos
);
    import sxb_pkg::*;

    logic [COL_W-1:0]    col_reg;
    logic [COL_W-1:0]    col_next;
    logic [ROW_W-1:0]    row_reg;
    logic [ROW_W-1:0]    row_next;
    logic [WIDTH_W:0]    width_round;
    logic [WIDTH_W-3:0]  row_cells;
    logic [COL_W-1:0]    last_col;
    logic [ROW_W-1:0]    last_row;
    logic                row_end;
    logic                bmp_end;

    // bytes per row, clamped to one..sixteen
    always_comb
    begin
        width_round = {1'b0, cfg.width_bits} + (WIDTH_W+1)'(7);
        row_cells   = width_round[WIDTH_W:3];
        if (row_cells == '0)
            last_col = '0;
        else if (row_cells > (WIDTH_W-2)'(MAX_ROW_CELLS))
            last_col = COL_W'(MAX_ROW_CELLS - 1);
        else
            last_col = COL_W'(row_cells - (WIDTH_W-2)'(1));
    end

    // rows, clamped to one..thirty-two
    always_comb
    begin
        if (cfg.height_rows == '0)
            last_row = '0;
        else if (cfg.height_rows > HEIGHT_W'(MAX_ROWS))
            last_row = ROW_W'(MAX_ROWS - 1);
        else
            last_row = ROW_W'(cfg.height_rows - HEIGHT_W'(1));
    end

    assign row_end = (col_reg >= last_col);
    assign bmp_end = row_end && (row_reg >= last_row);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (advance)
        begin
            if (bmp_end)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (row_end)
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign pos.col     = col_reg;
    assign pos.row     = row_reg;
    assign pos.bmp_end = bmp_end;

endmodule

// File: hw/rtl/sxb_update.sv
// ----------------------------------------------------------------------------
// sxb_update
// forms one frame update: the cell beat or the spill beat of a byte
// ----------------------------------------------------------------------------
module sxb_update #(
    parameter int unsigned ROW_BYTES  = sxb_pkg::ROW_BYTES_DEF,
    parameter int unsigned FRAME_ROWS = sxb_pkg::FRAME_ROWS_DEF
) (
    input  sxb_pkg::cfg_t                cfg,
    input  logic [sxb_pkg::DATA_W-1:0]   data,
    input  sxb_pkg::pos_t                pos,
    input  logic                         spill,
    output sxb_pkg::upd_t                upd
);
    import sxb_pkg::*;

    localparam int FRAME_SIZE = int'(FRAME_ROWS) * int'(ROW_BYTES);
    localparam int MAX_ADDR   = ((2**ORIGIN_Y_W - 1) + (2**ROW_W - 1)) * int'(ROW_BYTES)
                              + (2**(ORIGIN_X_W - SHIFT_W) - 1) + (2**COL_W - 1) + 1;
    localparam int SPAN_A     = (MAX_ADDR > FRAME_SIZE) ? MAX_ADDR : FRAME_SIZE;
    localparam int SPAN       = (SPAN_A > ADDR_LIMIT + 1) ? SPAN_A : ADDR_LIMIT + 1;
    localparam int ADDR_W     = $clog2(SPAN + 1);
    localparam int LINE_W     = ROW_W + 1;

    logic [SHIFT_W-1:0] shift;
    logic [LINE_W-1:0]  line;
    logic [ADDR_W-1:0]  addr;
    logic [DATA_W-1:0]  mask_cell;
    logic [DATA_W-1:0]  mask_spill;
    logic               last_item;

    assign shift = cfg.origin_x[SHIFT_W-1:0];
    assign line  = LINE_W'(cfg.origin_y) + LINE_W'(pos.row);

    assign addr = ADDR_W'(line) * ADDR_W'(ROW_BYTES)
                + ADDR_W'(cfg.origin_x[ORIGIN_X_W-1:SHIFT_W])
                + ADDR_W'(pos.col)
                + ADDR_W'(spill);

    assign mask_cell  = data << shift;
    assign mask_spill = data >> ((SHIFT_W+1)'(DATA_W) - (SHIFT_W+1)'(shift));

    // unshifted bytes give a single beat
    assign last_item = spill || (shift == '0);

    assign upd.frame_address  = addr[ADDR_OUT_W-1:0];
    assign upd.xor_mask       = spill ? mask_spill : mask_cell;
    assign upd.out_of_frame   = (addr >= ADDR_W'(FRAME_SIZE)) || (addr > ADDR_W'(ADDR_LIMIT));
    assign upd.last_of_item   = last_item;
    assign upd.last_of_bitmap = last_item && pos.bmp_end;

endmodule

// File: hw/rtl/shifted_xor_bitmap_blit_top.sv
// ----------------------------------------------------------------------------
// shifted_xor_bitmap_blit_top
// turns one-bit bitmap bytes into xor updates for a linear frame buffer
// ----------------------------------------------------------------------------
// Bitmap bytes arrive on the data channel, rows top to bottom, each row
// ceil(width_bits/8) bytes with bit 0 the leftmost pixel. Each byte leaves as
// xor beats that place the bitmap at pixel origin_x, origin_y in a frame of
// FRAME_ROWS rows of ROW_BYTES bytes. When origin_x is a multiple of eight a
// byte makes one beat; otherwise it makes two, the shifted byte at its own
// cell and then the spill at the next cell, which runs linearly into the next
// row past a row end. Beats beyond the frame still go out, with out_of_frame
// set and the low ten address bits. A byte is taken into a holding register
// and its beats are formed from there into a result register, so once its
// last beat is formed the data channel takes a new byte while that beat
// waits on the update channel. Throughput is set by the single result
// register: one byte per cycle when unshifted and the update channel is
// ready; a shifted byte holds the data channel until its spill beat is
// formed. Registers are written through the cfg port and should only change
// while the block is idle; a write does not clear the position counters.
// ----------------------------------------------------------------------------
module shifted_xor_bitmap_blit_top #(
    parameter int unsigned ROW_BYTES  = sxb_pkg::ROW_BYTES_DEF,
    parameter int unsigned FRAME_ROWS = sxb_pkg::FRAME_ROWS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port
    input  logic                               cfg_write_en,
    input  logic [sxb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sxb_pkg::CFG_DATA_W-1:0]     cfg_data,
    // bitmap byte channel
    input  logic                               data_valid,
    output logic                               data_ready,
    input  logic [sxb_pkg::DATA_W-1:0]         data_byte,
    // frame update channel
    output logic                               update_valid,
    input  logic                               update_ready,
    output logic [sxb_pkg::ADDR_OUT_W-1:0]     frame_address,
    output logic [sxb_pkg::DATA_W-1:0]         xor_mask,
    output logic                               out_of_frame,
    output logic                               last_of_item,
    output logic                               last_of_bitmap
);
    import sxb_pkg::*;

    cfg_t              cfg;
    pos_t              pos;
    upd_t              upd;
    logic              data_take;

    // holding register: one accepted byte and its bitmap position
    logic              item_valid_reg;
    logic              item_valid_next;
    logic [DATA_W-1:0] item_data_reg;
    pos_t              item_pos_reg;
    logic              spill_reg;
    logic              spill_next;

    // result register: one beat waiting on the update channel
    logic              out_valid_reg;
    logic              out_valid_next;
    upd_t              out_upd_reg;

    logic              out_load;
    logic              item_done;

    sxb_config u_config (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    // counters step once per accepted byte
    sxb_position u_position (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .advance (data_take),
        .pos     (pos)
    );

    sxb_update #(
        .ROW_BYTES  (ROW_BYTES),
        .FRAME_ROWS (FRAME_ROWS)
    ) u_update (
        .cfg   (cfg),
        .data  (item_data_reg),
        .pos   (item_pos_reg),
        .spill (spill_reg),
        .upd   (upd)
    );

    // a beat moves into the result register when it is empty or draining
    assign out_load  = item_valid_reg && (!out_valid_reg || update_ready);
    // the held byte retires with its last beat
    assign item_done = out_load && upd.last_of_item;

    assign data_ready = !item_valid_reg || item_done;
    assign data_take  = data_valid && data_ready;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        spill_next      = spill_reg;
        out_valid_next  = out_valid_reg;

        if (data_take)
            item_valid_next = 1'b1;
        else if (item_done)
            item_valid_next = 1'b0;

        // after the cell beat of a shifted byte comes its spill beat
        if (out_load)
            spill_next = !item_done;

        if (out_load)
            out_valid_next = 1'b1;
        else if (update_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            spill_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            spill_reg      <= spill_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (data_take)
        begin
            item_data_reg <= data_byte;
            item_pos_reg  <= pos;
        end
        if (out_load)
            out_upd_reg <= upd;
    end

    assign update_valid   = out_valid_reg;
    assign frame_address  = out_upd_reg.frame_address;
    assign xor_mask       = out_upd_reg.xor_mask;
    assign out_of_frame   = out_upd_reg.out_of_frame;
    assign last_of_item   = out_upd_reg.last_of_item;
    assign last_of_bitmap = out_upd_reg.last_of_bitmap;

endmodule

// File: tb/tb_shifted_xor_bitmap_blit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shifted_xor_bitmap_blit_top
// self-checking bench for the shifted xor bitmap blit
// ----------------------------------------------------------------------------
// Bitmap bytes go in on the data channel and every update beat that comes out
// is compared field by field against a behavioural copy of the blit that
// tracks its own registers and row/column position. A short table of directed
// rows comes first (register extremes, sizes that clamp, counters left past a
// new bitmap end, spill past the frame end), then random phases of whole
// bitmaps with the odd truncated one, each phase rewriting registers at random.
// ----------------------------------------------------------------------------
module tb_shifted_xor_bitmap_blit_top;

    import sxb_pkg::*;

    localparam int unsigned ROW_BYTES    = ROW_BYTES_DEF;
    localparam int unsigned FRAME_ROWS   = FRAME_ROWS_DEF;
    localparam int unsigned FRAME_BYTES  = ROW_BYTES * FRAME_ROWS;
    localparam int unsigned RANDOM_ITEMS = 1100;
    // first beat trails its byte through the holding and result registers; leave some margin
    localparam int unsigned SETTLE_CYCLES = 6;
    // cycles in a row with no beat on either channel before giving up
    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned NUM_DIRECTED  = 49;

    // expected beats caused by one bitmap byte; count zero means none given
    typedef struct packed {
        logic [1:0] count;
        upd_t       first;
        upd_t       second;
    } byte_updates_t;

    // one byte waiting to go out, with hand-typed beats where they are known
    typedef struct packed {
        logic [DATA_W-1:0] data;
        byte_updates_t     typed;
    } byte_item_t;

    typedef enum logic {
        ROW_WRITE,
        ROW_BYTE
    } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        cfg_reg_t          reg_index;
        logic [7:0]        value;
        byte_updates_t     typed;
    } directed_row_t;

    // directed table: register writes and bytes, beats typed in where obvious
    localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        // straight after reset: one byte per bitmap at address zero
        '{ROW_BYTE,  REG_ORIGIN_X,    8'h00, '{2'd1, '{10'd0, 8'h00, 1'b0, 1'b1, 1'b1}, '0}},
        '{ROW_BYTE,  REG_ORIGIN_X,    8'hFF, '{2'd1, '{10'd0, 8'hFF, 1'b0, 1'b1, 1'b1}, '0}},
        '{ROW_BYTE,  REG_ORIGIN_X,    8'hA5, '{2'd1, '{10'd0, 8'hA5, 1'b0, 1'b1, 1'b1}, '0}},
        // far corner, shift of seven: the spill lands just past the frame
        '{ROW_WRITE, REG_ORIGIN_X,    8'd127, '0},
        '{ROW_WRITE, REG_ORIGIN_Y,    8'd31,  '0},
        '{ROW_BYTE,  REG_ORIGIN_X,    8'hFF, '{2'd2, '{10'd511, 8'h80, 1'b0, 1'b0, 1'b0},
                                                    '{10'd512, 8'h7F, 1'b1, 1'b1, 1'b1}}},
        '{ROW_BYTE,  REG_ORIGIN_X,    8'h01, '{2'd2, '{10'd511, 8'h80, 1'b0, 1'b0, 1'b0},
                                                    '{10'd512, 8'h00, 1'b1, 1'b1, 1'b1}}},
        // shift of one at the origin
        '{ROW_WRITE, REG_ORIGIN_X,    8'd1,   '0},
        '{ROW_WRITE, REG_ORIGIN_Y,    8'd0,   '0},
        '{ROW_BYTE,  REG_ORIGIN_X,    8'h80, '{2'd2, '{10'd0, 8'h00, 1'b0, 1'b0, 1'b0},
                                                    '{10'd1, 8'h01, 1'b0, 1'b1, 1'b1}}},
        '{ROW_BYTE,  REG_ORIGIN_X,    8'h7F, '0},
        // largest legal bitmap, left part way through its first row
        '{ROW_WRITE, REG_ORIGIN_X,    8'd0,   '0},
        '{ROW_WRITE, REG_WIDTH_BITS,  8'd128, '0},
        '{ROW_WRITE, REG_HEIGHT_ROWS, 8'd32,  '0},
        '{ROW_BYTE,  REG_ORIGIN_X,    8'h3C, '0},
        '{ROW_BYTE,  REG_ORIGIN_X,    8'hC3, '0},
        '{ROW_BYTE,  REG_ORIGIN_X,    8'h96, '0},
        // shrink under the counters: the next byte ends the bitmap
        '{ROW_WRITE, REG_WIDTH_BITS,  8'd8,   '0},
        '{ROW_WRITE, REG_HEIGHT_ROWS, 8'd1,   '0},
        '{ROW_BYTE,  REG_ORIGIN_X,    8'h5A, '{2'd1, '{10'd3, 8'h5A, 1'b0, 1'b1, 1'b1}, '0}},
        // zero width and zero height both act as one
        '{ROW_WRITE, REG_WIDTH_BITS,  8'd0,   '0},
        '{ROW_WRITE, REG_HEIGHT_ROWS, 8'd0,   '0},
        '{ROW_BYTE,  REG_ORIGIN_X,    8'h81, '{2'd1, '{10'd0, 8'h81, 1'b0, 1'b1, 1'b1}, '0}},
        // oversize width and height clamp to the frame limits
        '{ROW_WRITE, REG_ORIGIN_X,    8'd8,   '0},
        '{ROW_WRITE, REG_ORIGIN_Y,    8'd31,  '0},
        '{ROW_WRITE, REG_WIDTH_BITS,  8'd255, '0},
        '{ROW_WRITE, REG_HEIGHT_ROWS, 8'd63,  '0},
        '{ROW_BYTE,  REG_ORIGIN_X,    8'h12, '0},
        '{ROW_BYTE,  REG_ORIGIN_X,    8'hFE, '0},
        // spill across a row end into the next frame row
        '{ROW_WRITE, REG_ORIGIN_X,    8'd127, '0},
        '{ROW_WRITE, REG_ORIGIN_Y,    8'd0,   '0},
        '{ROW_WRITE, REG_WIDTH_BITS,  8'd16,  '0},
        '{ROW_WRITE, REG_HEIGHT_ROWS, 8'd2,   '0},
        '{ROW_BYTE,  REG_ORIGIN_X,    8'hC3, '0},
        '{ROW_BYTE,  REG_ORIGIN_X,    8'h3C, '0},
        '{ROW_BYTE,  REG_ORIGIN_X,    8'h99, '0},
        // upper write bits beyond each register's width are dropped
        '{ROW_WRITE, REG_ORIGIN_X,    8'hF3,  '0},
        '{ROW_WRITE, REG_ORIGIN_Y,    8'hFF,  '0},
        '{ROW_WRITE, REG_WIDTH_BITS,  8'd9,   '0},
        '{ROW_WRITE, REG_HEIGHT_ROWS, 8'hC2,  '0},
        '{ROW_BYTE,  REG_ORIGIN_X,    8'h01, '0},
        '{ROW_BYTE,  REG_ORIGIN_X,    8'h80, '0},
        '{ROW_BYTE,  REG_ORIGIN_X,    8'h55, '0},
        '{ROW_BYTE,  REG_ORIGIN_X,    8'hAA, '0},
        // one pixel wide bitmap back at the origin
        '{ROW_WRITE, REG_WIDTH_BITS,  8'd1,   '0},
        '{ROW_WRITE, REG_HEIGHT_ROWS, 8'd1,   '0},
        '{ROW_WRITE, REG_ORIGIN_X,    8'd0,   '0},
        '{ROW_WRITE, REG_ORIGIN_Y,    8'd0,   '0},
        '{ROW_BYTE,  REG_ORIGIN_X,    8'hFF, '{2'd1, '{10'd0, 8'hFF, 1'b0, 1'b1, 1'b1}, '0}}
    };

    // dut ports, all inputs known from time zero
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_ORIGIN_X;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  data_valid = 1'b0;
    logic                  data_ready;
    logic [DATA_W-1:0]     data_byte = '0;
    logic                  update_valid;
    logic                  update_ready = 1'b0;
    logic [ADDR_OUT_W-1:0] frame_address;
    logic [DATA_W-1:0]     xor_mask;
    logic                  out_of_frame;
    logic                  last_of_item;
    logic                  last_of_bitmap;

    // shadow registers and position of the behavioural blit
    logic [ORIGIN_X_W-1:0] origin_x_reg = '0;
    logic [ORIGIN_Y_W-1:0] origin_y_reg = '0;
    logic [WIDTH_W-1:0]    width_reg    = WIDTH_W'(WIDTH_RESET);
    logic [HEIGHT_W-1:0]   height_reg   = HEIGHT_W'(HEIGHT_RESET);
    logic [COL_W-1:0]      col_pos      = '0;
    logic [ROW_W-1:0]      row_pos      = '0;

    byte_item_t bitmap_bytes [$];     // bytes still to be offered
    upd_t       pending_updates [$];  // beats owed by the dut, oldest first
    int unsigned send_idle_pct = 25;
    int unsigned recv_idle_pct = 55;
    int unsigned mismatches = 0;

    shifted_xor_bitmap_blit_top #(
        .ROW_BYTES      (ROW_BYTES),
        .FRAME_ROWS     (FRAME_ROWS)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .data_valid     (data_valid),
        .data_ready     (data_ready),
        .data_byte      (data_byte),
        .update_valid   (update_valid),
        .update_ready   (update_ready),
        .frame_address  (frame_address),
        .xor_mask       (xor_mask),
        .out_of_frame   (out_of_frame),
        .last_of_item   (last_of_item),
        .last_of_bitmap (last_of_bitmap)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // bytes per row after the zero and oversize clamps
    function automatic int unsigned row_cells();
        int unsigned cells;
        cells = (32'(width_reg) + 7) >> 3;
        if (cells == 0)
            cells = 1;
        if (cells > MAX_ROW_CELLS)
            cells = MAX_ROW_CELLS;
        return cells;
    endfunction

    // rows per bitmap after the same clamps
    function automatic int unsigned bitmap_rows();
        int unsigned rows;
        rows = 32'(height_reg);
        if (rows == 0)
            rows = 1;
        if (rows > MAX_ROWS)
            rows = MAX_ROWS;
        return rows;
    endfunction

    function automatic upd_t frame_beat(input int unsigned addr, input logic [7:0] mask,
                                        input logic item_end, input logic bitmap_end);
        upd_t beat;
        beat.frame_address  = addr[ADDR_OUT_W-1:0];
        beat.xor_mask       = mask;
        beat.out_of_frame   = (addr >= FRAME_BYTES) || (addr > ADDR_LIMIT);
        beat.last_of_item   = item_end;
        beat.last_of_bitmap = bitmap_end;
        return beat;
    endfunction

    // beats for one bitmap byte at the current position, then step the position
    function automatic byte_updates_t blit_byte(input logic [7:0] pixels);
        byte_updates_t res;
        int unsigned   cell_addr;
        logic [2:0]    shift;
        logic          row_done;
        logic          bitmap_done;
        res = '0;
        shift = origin_x_reg[2:0];
        cell_addr = (32'(origin_y_reg) + 32'(row_pos)) * ROW_BYTES
                  + 32'(origin_x_reg[ORIGIN_X_W-1:3]) + 32'(col_pos);
        // counters left beyond a shrunk bitmap count as its last position
        row_done = 32'(col_pos) >= row_cells() - 1;
        bitmap_done = row_done && (32'(row_pos) >= bitmap_rows() - 1);
        if (shift == 3'd0)
        begin
            res.count = 2'd1;
            res.first = frame_beat(cell_addr, pixels, 1'b1, bitmap_done);
        end
        else
        begin
            // shifted byte in its own cell, then the spill in the next one
            res.count  = 2'd2;
            res.first  = frame_beat(cell_addr, pixels << shift, 1'b0, 1'b0);
            res.second = frame_beat(cell_addr + 1, pixels >> (4'd8 - 4'(shift)),
                                    1'b1, bitmap_done);
        end
        if (bitmap_done)
        begin
            col_pos = '0;
            row_pos = '0;
        end
        else if (row_done)
        begin
            col_pos = '0;
            row_pos = row_pos + 1'b1;
        end
        else
            col_pos = col_pos + 1'b1;
        return res;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // register write through the cfg port, mirrored into the shadow copy
    task automatic write_reg(input cfg_reg_t idx, input logic [7:0] val);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        case (idx)
            REG_ORIGIN_X:    origin_x_reg = val[ORIGIN_X_W-1:0];
            REG_ORIGIN_Y:    origin_y_reg = val[ORIGIN_Y_W-1:0];
            REG_WIDTH_BITS:  width_reg    = val[WIDTH_W-1:0];
            REG_HEIGHT_ROWS: height_reg   = val[HEIGHT_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // block idle: nothing queued, nothing offered, every owed beat seen
    task automatic wait_idle();
        do
            @(negedge clk);
        while (bitmap_bytes.size() != 0 || data_valid || pending_updates.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // data channel: on each accepted beat work out what the dut owes, then
    // offer the next byte unless this cycle is an idle one
    always @(posedge clk)
    begin : byte_sender
        byte_item_t    in_flight;
        byte_updates_t owed;
        if (data_valid && data_ready)
        begin
            owed = blit_byte(data_byte);
            // typed rows override the prediction, position still advances
            if (in_flight.typed.count != 2'd0)
                owed = in_flight.typed;
            pending_updates.push_back(owed.first);
            if (owed.count == 2'd2)
                pending_updates.push_back(owed.second);
        end
        if (!data_valid || data_ready)
        begin
            if (bitmap_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_flight = bitmap_bytes.pop_front();
                data_valid <= 1'b1;
                data_byte  <= in_flight.data;
            end
            else
                data_valid <= 1'b0;
        end
    end

    // update channel back-pressure
    always @(posedge clk)
    begin
        update_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // every accepted update beat against the oldest owed one
    always @(posedge clk)
    begin : update_checker
        upd_t want;
        if (update_valid && update_ready)
        begin
            if (pending_updates.size() == 0)
            begin
                $error("update beat with none owed: frame_address 0x%0h", frame_address);
                mismatches++;
            end
            else
            begin
                want = pending_updates.pop_front();
                check_field("frame_address", want.frame_address, frame_address);
                check_field("xor_mask", want.xor_mask, xor_mask);
                check_field("out_of_frame", want.out_of_frame, out_of_frame);
                check_field("last_of_item", want.last_of_item, last_of_item);
                check_field("last_of_bitmap", want.last_of_bitmap, last_of_bitmap);
            end
        end
    end

    // hang detection: too long with no beat on either channel
    initial
    begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((data_valid && data_ready) || (update_valid && update_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : stimulus
        directed_row_t row;
        byte_item_t    item;
        int unsigned   random_sent;
        int unsigned   bitmap_size;
        int unsigned   batch;
        int unsigned   pick;
        logic [7:0]    val;
        random_sent = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed table; registers only change with the block idle
        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            row = DIRECTED_ROWS[i];
            if (row.kind == ROW_WRITE)
            begin
                wait_idle();
                write_reg(row.reg_index, row.value);
            end
            else
            begin
                @(negedge clk);
                item.data  = row.value;
                item.typed = row.typed;
                bitmap_bytes.push_back(item);
            end
        end

        // random phases: new register values, then whole bitmaps with random
        // pixels, now and then cut short so the next phase starts mid-bitmap
        while (random_sent < RANDOM_ITEMS)
        begin
            wait_idle();
            for (int r = 0; r < 4; r++)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    pick = $urandom_range(0, 99);
                    case (cfg_reg_t'(r))
                        REG_WIDTH_BITS:
                            // mostly narrow; sometimes zero, oversize or wide
                            if (pick < 5)
                                val = 8'd0;
                            else if (pick < 12)
                                val = 8'($urandom_range(129, 255));
                            else if (pick < 20)
                                val = 8'($urandom_range(41, 128));
                            else
                                val = 8'($urandom_range(1, 40));
                        REG_HEIGHT_ROWS:
                        begin
                            // mostly short; junk in the two bits above the register
                            if (pick < 5)
                                val = 8'd0;
                            else if (pick < 10)
                                val = 8'($urandom_range(33, 63));
                            else if (pick < 18)
                                val = 8'($urandom_range(5, 32));
                            else
                                val = 8'($urandom_range(1, 4));
                            val[7:6] = 2'($urandom_range(0, 3));
                        end
                        default:
                            val = 8'($urandom_range(0, 255));
                    endcase
                    write_reg(cfg_reg_t'(r), val);
                end
            end

            bitmap_size = row_cells() * bitmap_rows();
            batch = (bitmap_size > 64) ? bitmap_size : $urandom_range(1, 3) * bitmap_size;
            if ($urandom_range(0, 99) < 15)
                batch = $urandom_range(1, bitmap_size);
            // keep the total close to the planned item count
            if (batch > RANDOM_ITEMS - random_sent)
                batch = RANDOM_ITEMS - random_sent;

            // idling pattern by progress: sender light, then receiver light, then none
            @(negedge clk);
            if (random_sent < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 25;
                recv_idle_pct = 55;
            end
            else if (random_sent < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 55;
                recv_idle_pct = 25;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            repeat (batch)
            begin
                pick = $urandom_range(0, 9);
                item.typed = '0;
                item.data = (pick == 0) ? 8'h00 :
                            (pick == 1) ? 8'hFF : 8'($urandom_range(0, 255));
                bitmap_bytes.push_back(item);
            end
            random_sent += batch;
        end

        // drain, let any stray beats show up, then the verdict
        wait_idle();
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/sxb_pkg.sv
hw/rtl/sxb_config.sv
hw/rtl/sxb_position.sv
hw/rtl/sxb_update.sv
hw/rtl/shifted_xor_bitmap_blit_top.sv
tb/tb_shifted_xor_bitmap_blit_top.sv
